@@ hdl/four_level_page_walk_translate_defines.svh @@
// assertion macros for the page walker
`ifndef FOUR_LEVEL_PAGE_WALK_TRANSLATE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_WALK_TRANSLATE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ hdl/flpwt_pkg.sv @@
package flpwt_pkg;

	localparam int VA_BITS        = 48;
	localparam int PORT_ADDR_BITS = 52;
	localparam int DATA_BITS      = 64;
	localparam int IDX_BITS       = 9;
	localparam int OFF_4K_BITS    = 12;
	localparam int OFF_2M_BITS    = 21;
	localparam int OFF_1G_BITS    = 30;
	localparam int PRESENT_BIT    = 0;
	localparam int BIG_BIT        = 7;
	localparam logic [PORT_ADDR_BITS-1:0] ROOT_RESET = 52'h0_0000_0000_1000;

	typedef enum logic {
		CMD_TRANSLATE = 1'b0,
		CMD_RESPONSE  = 1'b1
	} command_t;

	typedef enum logic {
		KIND_READ = 1'b0,
		KIND_DONE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		PAGE_4K = 2'd0,
		PAGE_2M = 2'd1,
		PAGE_1G = 2'd2
	} page_size_t;

	typedef enum logic [1:0] {
		LVL_PML4 = 2'd0,
		LVL_PDPT = 2'd1,
		LVL_PD   = 2'd2,
		LVL_PT   = 2'd3
	} level_t;

	typedef struct packed {
		logic                 command;
		logic [VA_BITS-1:0]   virtual_address;
		logic [DATA_BITS-1:0] read_data;
	} in_item_t;

	typedef struct packed {
		logic                      result_kind;
		logic [PORT_ADDR_BITS-1:0] read_address;
		logic [PORT_ADDR_BITS-1:0] physical_address;
		logic                      fault;
		logic [1:0]                page_size;
	} out_item_t;

	function automatic logic [IDX_BITS-1:0] table_index(logic [VA_BITS-1:0] va,
			logic [1:0] level);
		logic [IDX_BITS-1:0] idx;
		case (level)
			LVL_PML4: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

@@ hdl/flpwt_chan_if.sv @@
interface flpwt_chan_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/flpwt_walk.sv @@
module flpwt_walk #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  flpwt_pkg::in_item_t       item_s1,
	input  logic [PHYS_ADDR_BITS-1:0] root,
	output flpwt_pkg::out_item_t      res,
	output logic                      res_valid
);
	import flpwt_pkg::*;

	logic [1:0]                level_q, level_d, next_level;
	logic                      busy_q, busy_d;
	logic [VA_BITS-1:0]        va_q, va_d;
	logic [PHYS_ADDR_BITS-1:0] base, tbl, req_addr, pa;
	logic [IDX_BITS-1:0]       idx;
	logic                      present, big, translate;

	assign translate  = (item_s1.command == CMD_TRANSLATE);
	assign present    = item_s1.read_data[PRESENT_BIT];
	assign big        = item_s1.read_data[BIG_BIT];
	assign next_level = level_q + 2'd1;
	assign base       = {item_s1.read_data[PHYS_ADDR_BITS-1:OFF_4K_BITS], {OFF_4K_BITS{1'b0}}};
	assign tbl        = translate ? root : base;
	assign idx        = translate ? table_index(item_s1.virtual_address, LVL_PML4)
	                              : table_index(va_q, next_level);
	assign req_addr   = {tbl[PHYS_ADDR_BITS-1:OFF_4K_BITS], idx, 3'b000};

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		level_d   = level_q;
		busy_d    = busy_q;
		va_d      = va_q;
		pa        = '0;
		if (translate) begin
			va_d             = item_s1.virtual_address;
			level_d          = LVL_PML4;
			busy_d           = 1'b1;
			res_valid        = 1'b1;
			res.result_kind  = KIND_READ;
			res.read_address = PORT_ADDR_BITS'(req_addr);
		end else if (busy_q) begin
			res_valid       = 1'b1;
			busy_d          = 1'b0;
			level_d         = LVL_PML4;
			res.result_kind = KIND_DONE;
			if (!present) begin
				res.fault = 1'b1;
			end else if (level_q == LVL_PDPT && big) begin
				pa                   = {base[PHYS_ADDR_BITS-1:OFF_1G_BITS], va_q[OFF_1G_BITS-1:0]};
				res.physical_address = PORT_ADDR_BITS'(pa);
				res.page_size        = PAGE_1G;
			end else if (level_q == LVL_PD && big) begin
				pa                   = {base[PHYS_ADDR_BITS-1:OFF_2M_BITS], va_q[OFF_2M_BITS-1:0]};
				res.physical_address = PORT_ADDR_BITS'(pa);
				res.page_size        = PAGE_2M;
			end else if (level_q == LVL_PT) begin
				pa                   = {base[PHYS_ADDR_BITS-1:OFF_4K_BITS], va_q[OFF_4K_BITS-1:0]};
				res.physical_address = PORT_ADDR_BITS'(pa);
				res.page_size        = PAGE_4K;
			end else begin
				busy_d           = 1'b1;
				level_d          = next_level;
				res.result_kind  = KIND_READ;
				res.read_address = PORT_ADDR_BITS'(req_addr);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_PML4;
			busy_q  <= 1'b0;
		end else if (fire) begin
			level_q <= level_d;
			busy_q  <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			va_q <= va_d;
		end
	end

endmodule

@@ hdl/flpwt_out_reg.sv @@
module flpwt_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  flpwt_pkg::out_item_t d,
	input  logic                 ready,
	output logic                 valid,
	output flpwt_pkg::out_item_t q,
	output logic                 space
);
	import flpwt_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	assign space = !valid_q || ready;
	assign valid = valid_q;
	assign q     = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

endmodule

@@ hdl/four_level_page_walk_translate.sv @@
// channel  role    payload
// cmd      sink    in_item_t: command, virtual_address, read_data
// rsp      source  out_item_t: result_kind, read_address, physical_address, fault, page_size
// cfg      sink    52-bit root_table_base, always ready
//
// one request per cycle while cmd.ready is high; a taken request is held in the input
// register, then the walk step writes any result it has into the output register
// arst_n clears all valid flags, puts the walker idle and loads root_table_base = 0x1000
// cmd.ready drops only while the held request has a result and the output register
// is full and rsp.ready is low
`include "four_level_page_walk_translate_defines.svh"

module four_level_page_walk_translate #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input logic         clk,
	input logic         arst_n,
	flpwt_chan_if.sink   cmd,
	flpwt_chan_if.source rsp,
	flpwt_chan_if.sink   cfg
);
	import flpwt_pkg::*;

	logic [PHYS_ADDR_BITS-1:0] root_q;
	logic                      valid_s1;
	in_item_t                  item_s1;
	out_item_t                 res;
	logic                      res_valid, fire, space, load;

	assign cfg.ready = 1'b1;
	assign fire      = valid_s1 && (space || !res_valid);
	assign load      = fire && res_valid;
	assign cmd.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= ROOT_RESET[PHYS_ADDR_BITS-1:0];
		end else if (cfg.valid) begin
			root_q <= cfg.data[PHYS_ADDR_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.data;
		end
	end

	flpwt_walk #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item_s1  (item_s1),
		.root     (root_q),
		.res      (res),
		.res_valid(res_valid)
	);

	flpwt_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (load),
		.d     (res),
		.ready (rsp.ready),
		.valid (rsp.valid),
		.q     (rsp.data),
		.space (space)
	);

	`ASSERT_NEXT(a_translate_issues_read, clk, arst_n, fire && item_s1.command == CMD_TRANSLATE, rsp.valid && rsp.data.result_kind == KIND_READ)
	`ASSERT_NEXT(a_held_request_waits, clk, arst_n, valid_s1 && !fire, valid_s1 && $stable(item_s1))
	`ASSERT_IMPLY(a_fault_has_no_page, clk, arst_n, rsp.valid && rsp.data.fault, rsp.data.page_size == PAGE_4K && rsp.data.physical_address == '0 && rsp.data.result_kind == KIND_DONE)

endmodule
